// ===== design/hsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants of the HSV to RGB converter
// Request types between the front and back parts, arithmetic constants.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam logic [8:0]  HUE_TURN        = 9'd360;
	localparam logic [15:0] HUE_RECIP       = 16'd46604;
	localparam int          HUE_RECIP_SHIFT = 24;
	localparam logic [5:0]  SECTOR_SPAN     = 6'd60;
	localparam logic [7:0]  LEVEL_FULL      = 8'd255;
	localparam logic [13:0] SECTOR_DENOM    = 14'd15300;
	localparam logic [22:0] DENOM_RECIP     = 23'd4491470;
	localparam int          DENOM_SHIFT     = 36;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t    sector;
		logic [5:0] rem;
		logic [7:0] sat;
		logic [7:0] val;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} item_req_t;

	typedef struct packed {
		logic valid;
		rgb_t rgb;
	} rgb_req_t;

endpackage

// ===== design/hsv_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_fifo: short request queue
// Register-based first-in first-out queue with an occupancy count.
// ----------------------------------------------------------------------------
module hsv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_rd;

	assign do_rd   = rd_en && (count_q != '0);
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/hsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_front: request intake and hue classification
// Reduce the hue modulo 360, split it into sector and remainder, and issue
// only when the queue behind has room for everything in flight.
// ----------------------------------------------------------------------------
module hsv_front
	import hsv_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [15:0]    hue_degrees,
	input  logic [7:0]     saturation_level,
	input  logic [7:0]     value_level,
	input  logic [CW-1:0]  queue_count,
	output item_req_t      req
);

	logic        v_s1;
	logic [15:0] hue_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1;
	logic [7:0]  quot_s1;
	logic        v_s2;
	item_t       item_s2;

	logic        accept;
	logic [1:0]  inflight;
	logic [CW:0] used;
	logic [31:0] quot_prod;
	logic [16:0] h_full;
	logic [8:0]  h;
	sector_t     sector;
	logic [8:0]  base;
	logic [8:0]  rem_full;

	assign inflight  = {1'b0, v_s1} + {1'b0, v_s2};
	assign used      = {1'b0, queue_count} + (CW + 1)'(inflight);
	assign full      = (used >= (CW + 1)'(QUEUE_DEPTH));
	assign accept    = push && !full;
	assign quot_prod = 32'(hue_degrees) * 32'(HUE_RECIP);

	assign h_full   = 17'(hue_s1) - (17'(quot_s1) * 17'(HUE_TURN));
	assign h        = h_full[8:0];
	assign rem_full = h - base;

	always_comb begin
		if (h < 9'd60) begin
			sector = SEC_0;
			base   = 9'd0;
		end else if (h < 9'd120) begin
			sector = SEC_1;
			base   = 9'd60;
		end else if (h < 9'd180) begin
			sector = SEC_2;
			base   = 9'd120;
		end else if (h < 9'd240) begin
			sector = SEC_3;
			base   = 9'd180;
		end else if (h < 9'd300) begin
			sector = SEC_4;
			base   = 9'd240;
		end else begin
			sector = SEC_5;
			base   = 9'd300;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hue_s1  <= hue_degrees;
			sat_s1  <= saturation_level;
			val_s1  <= value_level;
			quot_s1 <= quot_prod[HUE_RECIP_SHIFT +: 8];
		end
		if (v_s1) begin
			item_s2.sector <= sector;
			item_s2.rem    <= rem_full[5:0];
			item_s2.sat    <= sat_s1;
			item_s2.val    <= val_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign req.valid = v_s2;
	assign req.item  = item_s2;

endmodule

// ===== design/hsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_back: channel arithmetic and routing
// Form p, q and t with exact floor division, route them by sector and
// issue only when the result queue has room for everything in flight.
// ----------------------------------------------------------------------------
module hsv_back
	import hsv_pkg::*;
#(
	parameter int OUT_DEPTH = 8,
	localparam int CW = $clog2(OUT_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mid_empty,
	input  item_t         mid_item,
	output logic          mid_pop,
	input  logic [CW-1:0] out_count,
	output rgb_req_t      res
);

	logic        v_s1;
	item_t       item_s1;
	logic [13:0] sr_s1;
	logic [13:0] st_s1;
	logic        v_s2;
	sector_t     sector_s2;
	logic [7:0]  val_s2;
	logic [21:0] prod_q_s2;
	logic [21:0] prod_t_s2;
	logic [15:0] prod_p_s2;
	logic        v_s3;
	rgb_t        rgb_s3;

	logic [1:0]  inflight;
	logic [CW:0] used;
	logic [13:0] nq;
	logic [13:0] nt;
	logic [44:0] wq;
	logic [44:0] wt;
	logic [16:0] wp;
	logic [7:0]  p;
	logic [7:0]  q;
	logic [7:0]  t;
	rgb_t        rgb;

	assign inflight = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);
	assign used     = {1'b0, out_count} + (CW + 1)'(inflight);
	assign mid_pop  = !mid_empty && (used < (CW + 1)'(OUT_DEPTH));

	assign nq = SECTOR_DENOM - sr_s1;
	assign nt = SECTOR_DENOM - st_s1;

	assign wq = 45'(prod_q_s2) * 45'(DENOM_RECIP);
	assign wt = 45'(prod_t_s2) * 45'(DENOM_RECIP);
	assign wp = 17'(prod_p_s2) + 17'(prod_p_s2[15:8]) + 17'd1;
	assign q  = wq[DENOM_SHIFT +: 8];
	assign t  = wt[DENOM_SHIFT +: 8];
	assign p  = wp[15:8];

	always_comb begin
		case (sector_s2)
			SEC_0:   rgb = '{red: val_s2, green: t,      blue: p};
			SEC_1:   rgb = '{red: q,      green: val_s2, blue: p};
			SEC_2:   rgb = '{red: p,      green: val_s2, blue: t};
			SEC_3:   rgb = '{red: p,      green: q,      blue: val_s2};
			SEC_4:   rgb = '{red: t,      green: p,      blue: val_s2};
			default: rgb = '{red: val_s2, green: p,      blue: q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			item_s1 <= mid_item;
			sr_s1   <= 14'(mid_item.sat) * 14'(mid_item.rem);
			st_s1   <= 14'(mid_item.sat) * 14'(SECTOR_SPAN - mid_item.rem);
		end
		if (v_s1) begin
			sector_s2 <= item_s1.sector;
			val_s2    <= item_s1.val;
			prod_q_s2 <= 22'(item_s1.val) * 22'(nq);
			prod_t_s2 <= 22'(item_s1.val) * 22'(nt);
			prod_p_s2 <= 16'(item_s1.val) * 16'(LEVEL_FULL - item_s1.sat);
		end
		if (v_s2) begin
			rgb_s3 <= rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign res.valid = v_s3;
	assign res.rgb   = rgb_s3;

endmodule

// ===== design/hsv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top: HSV to RGB color converter
// Front classifies hue, a short queue decouples it from the arithmetic back
// part, and a result queue holds finished colors until popped.
// ----------------------------------------------------------------------------
//  channel  handshake     payload
//  input    push / full   hue_degrees, saturation_level, value_level
//  result   pop / empty   red_level, green_level, blue_level
//
//  One request per cycle sustained while full stays low; a result passes
//  two front stages, middle queue, three back stages and the result queue.
//  Reset clears stage valid bits and queue pointers; no clearing pass.
//  While pop is held low, full rises once in-flight work plus queued
//  entries fill the queues, and falls again as results drain.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
	import hsv_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] hue_degrees,
	input  logic [7:0]  saturation_level,
	input  logic [7:0]  value_level,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red_level,
	output logic [7:0]  green_level,
	output logic [7:0]  blue_level
);

	localparam int MID_CW = $clog2(MID_DEPTH + 1);
	localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

	item_req_t                front_req;
	logic [$bits(item_t)-1:0] mid_data;
	logic                     mid_empty;
	logic                     mid_pop;
	logic [MID_CW-1:0]        mid_count;
	rgb_req_t                 back_res;
	logic [$bits(rgb_t)-1:0]  out_data;
	logic [OUT_CW-1:0]        out_count;
	rgb_t                     out_rgb;

	hsv_front #(
		.QUEUE_DEPTH(MID_DEPTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.hue_degrees      (hue_degrees),
		.saturation_level (saturation_level),
		.value_level      (value_level),
		.queue_count      (mid_count),
		.req              (front_req)
	);

	hsv_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_req.valid),
		.wr_data (front_req.item),
		.rd_en   (mid_pop),
		.rd_data (mid_data),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	hsv_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (item_t'(mid_data)),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.res       (back_res)
	);

	hsv_fifo #(
		.WIDTH($bits(rgb_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_res.valid),
		.wr_data (back_res.rgb),
		.rd_en   (pop),
		.rd_data (out_data),
		.empty   (empty),
		.count   (out_count)
	);

	assign out_rgb     = rgb_t'(out_data);
	assign red_level   = out_rgb.red;
	assign green_level = out_rgb.green;
	assign blue_level  = out_rgb.blue;

endmodule
